// ===== hdl/eis_pkg.sv =====
// Shared types and constants for the epoch index sampler.
package eis_pkg;

  localparam int ALU_W  = 17;
  localparam int ALU_RW = 2 * ALU_W;
  localparam int DATA_W = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic MODE_SEQ  = 1'b0;
  localparam logic MODE_RAND = 1'b1;

  localparam logic REG_VOLUME = 1'b0;
  localparam logic REG_DEPTH  = 1'b1;

  typedef enum logic [1:0] {
    STS_INDEX    = 2'd0,
    STS_FINISHED = 2'd1,
    STS_REJECT   = 2'd2,
    STS_STARTED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SEQ  = 2'd1,
    KIND_RAND = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ALU_SUB = 2'd0,
    ALU_MUL = 2'd1,
    ALU_ADD = 2'd2
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_LEN   = 3'd2,
    ST_CHECK = 3'd3,
    ST_MUL   = 3'd4,
    ST_READ  = 3'd5,
    ST_TEST  = 3'd6,
    ST_OFFS  = 3'd7
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } map_ctl_t;

endpackage

// ===== hdl/epoch_index_sampler_core.sv =====
// Top level of the epoch index sampler: register port, sequencer, ALU, used map.
// A start word with start high is taken when busy is low; exactly one result
// word follows, shown for one cycle with result_valid high, and the receiver
// cannot stall it. Length, pick and offset arithmetic runs through one shared
// subtract/multiply/add unit run by the sequencer; the used map is single-port.
// A sequential start answers directly; a randomized one first clears the map,
// one entry per cycle. A next reports finished on an exhausted epoch, else it
// picks a unit (randomized: multiply, reject a bad or used pick, mark it) and
// adds the offset. The next word can be taken in the cycle result_valid is
// high. After reset the map is cleared with busy high; register writes are
// taken throughout. Registers: data_volume at byte 0, feedback_depth at byte 4.
module epoch_index_sampler_core #(
  parameter int MAX_EPOCH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic        order_mode,
  input  logic [15:0] random_word,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [15:0] unit_index
);
  import eis_pkg::*;

  localparam int PW = (MAX_EPOCH > 1) ? $clog2(MAX_EPOCH) : 1;

  logic [15:0]       data_volume, feedback_depth;
  alu_op_t           alu_op;
  logic [ALU_W-1:0]  alu_a, alu_b;
  logic [ALU_RW-1:0] alu_res;
  map_ctl_t          map_ctl;
  logic [PW-1:0]     map_addr;
  logic              map_rdata;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_volume    <= '0;
      feedback_depth <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VOLUME) begin
        data_volume <= pwdata[15:0];
      end else begin
        feedback_depth <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_VOLUME) begin
      prdata = 32'(data_volume);
    end else begin
      prdata = 32'(feedback_depth);
    end
  end

  eis_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  eis_used_map #(
    .DEPTH (MAX_EPOCH),
    .AW    (PW)
  ) u_map (
    .clk   (clk),
    .ctl   (map_ctl),
    .addr  (map_addr),
    .rdata (map_rdata)
  );

  eis_ctrl #(
    .MAX_EPOCH (MAX_EPOCH),
    .PW        (PW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .order_mode     (order_mode),
    .random_word    (random_word),
    .data_volume    (data_volume),
    .feedback_depth (feedback_depth),
    .result_valid   (result_valid),
    .status         (status),
    .unit_index     (unit_index),
    .alu_op         (alu_op),
    .alu_a          (alu_a),
    .alu_b          (alu_b),
    .alu_res        (alu_res),
    .map_ctl        (map_ctl),
    .map_addr       (map_addr),
    .map_rdata      (map_rdata)
  );

endmodule

// ===== hdl/eis_alu.sv =====
// Shared subtract / multiply / add unit.
module eis_alu (
  input  eis_pkg::alu_op_t                 op,
  input  logic [eis_pkg::ALU_W-1:0]        a,
  input  logic [eis_pkg::ALU_W-1:0]        b,
  output logic [eis_pkg::ALU_RW-1:0]       res
);
  import eis_pkg::*;

  always_comb begin
    unique case (op)
      ALU_SUB: res = ALU_RW'(a) - ALU_RW'(b);
      ALU_MUL: res = ALU_RW'(a) * ALU_RW'(b);
      ALU_ADD: res = ALU_RW'(a) + ALU_RW'(b);
      default: res = '0;
    endcase
  end

endmodule

// ===== hdl/eis_used_map.sv =====
// Used-unit bitmap memory, one port, registered read.
module eis_used_map #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  eis_pkg::map_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  output logic              rdata
);
  import eis_pkg::*;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/eis_ctrl.sv =====
// Sequencer and datapath registers of the epoch index sampler.
module eis_ctrl #(
  parameter int MAX_EPOCH = 1024,
  parameter int PW        = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic                         order_mode,
  input  logic [15:0]                  random_word,
  input  logic [15:0]                  data_volume,
  input  logic [15:0]                  feedback_depth,
  output logic                         result_valid,
  output logic [1:0]                   status,
  output logic [15:0]                  unit_index,
  output eis_pkg::alu_op_t             alu_op,
  output logic [eis_pkg::ALU_W-1:0]    alu_a,
  output logic [eis_pkg::ALU_W-1:0]    alu_b,
  input  logic [eis_pkg::ALU_RW-1:0]   alu_res,
  output eis_pkg::map_ctl_t            map_ctl,
  output logic [PW-1:0]                map_addr,
  input  logic                         map_rdata
);
  import eis_pkg::*;

  localparam int LW = $clog2(MAX_EPOCH + 1);

  state_t          state, state_next;
  kind_t           kind;
  logic [LW-1:0]   len_r, done_count, len_calc;
  logic [PW-1:0]   pick_r, clr_cnt;
  logic [15:0]     rnd_r;
  logic            pick_bad, clr_emit, clr_last, accept, exhausted;
  logic [ALU_W-1:0] diff, pick_full;
  logic            emit;
  status_t         emit_status;
  logic [15:0]     emit_index;
  status_t         status_r;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign clr_last  = (clr_cnt == PW'(MAX_EPOCH - 1));
  assign exhausted = (kind == KIND_NONE) || (done_count >= len_r);
  assign diff      = alu_res[ALU_W-1:0];
  assign pick_full = alu_res[DATA_W +: ALU_W];
  assign status    = status_r;

  // epoch length: zero on borrow, saturated at MAX_EPOCH
  always_comb begin
    if (diff[ALU_W-1]) begin
      len_calc = '0;
    end else if (diff > ALU_W'(MAX_EPOCH)) begin
      len_calc = LW'(MAX_EPOCH);
    end else begin
      len_calc = LW'(diff);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: state_next = clr_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_NEXT) begin
            state_next = ST_LEN;
          end else if (order_mode == MODE_RAND) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_LEN: state_next = ST_CHECK;
      ST_CHECK: begin
        if (exhausted) begin
          state_next = ST_IDLE;
        end else if (kind == KIND_SEQ) begin
          state_next = ST_OFFS;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_READ;
      ST_READ: state_next = pick_bad ? ST_IDLE : ST_TEST;
      ST_TEST: state_next = map_rdata ? ST_IDLE : ST_OFFS;
      ST_OFFS: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    map_ctl     = '0;
    map_addr    = pick_r;
    emit        = 1'b0;
    emit_status = STS_INDEX;
    emit_index  = '0;
    unique case (state)
      ST_CLEAR: begin
        map_ctl.wr = 1'b1;
        map_addr   = clr_cnt;
        if (clr_last && clr_emit) begin
          emit        = 1'b1;
          emit_status = STS_STARTED;
        end
      end
      ST_IDLE: begin
        if (accept && operation == OP_START && order_mode == MODE_SEQ) begin
          emit        = 1'b1;
          emit_status = STS_STARTED;
        end
      end
      ST_LEN: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(data_volume);
        alu_b  = ALU_W'(feedback_depth);
      end
      ST_CHECK: begin
        if (exhausted) begin
          emit        = 1'b1;
          emit_status = STS_FINISHED;
        end
      end
      ST_MUL: begin
        alu_op = ALU_MUL;
        alu_a  = ALU_W'(len_r);
        alu_b  = ALU_W'(rnd_r);
      end
      ST_READ: begin
        if (pick_bad) begin
          emit        = 1'b1;
          emit_status = STS_REJECT;
        end else begin
          map_ctl.rd = 1'b1;
        end
      end
      ST_TEST: begin
        if (map_rdata) begin
          emit        = 1'b1;
          emit_status = STS_REJECT;
        end else begin
          map_ctl.wr    = 1'b1;
          map_ctl.wdata = 1'b1;
        end
      end
      ST_OFFS: begin
        alu_op      = ALU_ADD;
        alu_a       = ALU_W'(pick_r);
        alu_b       = ALU_W'(feedback_depth);
        emit        = 1'b1;
        emit_status = STS_INDEX;
        emit_index  = alu_res[DATA_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      clr_emit     <= 1'b0;
      kind         <= KIND_NONE;
      done_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
        if (clr_last) begin
          clr_emit <= 1'b0;
        end
      end
      if (state == ST_IDLE && accept && operation == OP_START) begin
        done_count <= '0;
        if (order_mode == MODE_RAND) begin
          kind     <= KIND_RAND;
          clr_emit <= 1'b1;
        end else begin
          kind <= KIND_SEQ;
        end
      end
      if (state == ST_OFFS) begin
        done_count <= done_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r   <= emit_status;
      unit_index <= emit_index;
    end
    if (accept) begin
      rnd_r <= random_word;
    end
    if (state == ST_LEN) begin
      len_r <= len_calc;
    end
    if (state == ST_CHECK) begin
      pick_r <= done_count[PW-1:0];
    end
    if (state == ST_MUL) begin
      pick_r   <= pick_full[PW-1:0];
      pick_bad <= (pick_full >= ALU_W'(len_r));
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_IDLE && map_ctl.wr))
    else $error("used map written while idle");

  a_mark_only_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST && map_ctl.wr) |-> !map_rdata)
    else $error("marking a unit that is already used");

  a_index_counts: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status_r == STS_INDEX) |->
      (done_count == LW'($past(done_count) + 1'b1)))
    else $error("index given without advancing the count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status_r == STS_INDEX) |-> (done_count <= len_r))
    else $error("more indexes than the epoch holds");

endmodule
